@@ design/cascaded_event_interrupt_controller_macros.svh @@
// Assertion helpers used by the controller's core module.
`ifndef CASCADED_EVENT_INTERRUPT_CONTROLLER_MACROS_SVH
`define CASCADED_EVENT_INTERRUPT_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CEIC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define CEIC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ design/ceic_pkg.sv @@
package ceic_pkg;

   localparam int PEND_WORDS = 3;
   localparam int MASK_WORDS = 9;

   typedef enum logic [1:0] {
      CMD_RAISE = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   localparam logic [3:0] SEL_PEND0      = 4'd0;
   localparam logic [3:0] SEL_PEND1      = 4'd1;
   localparam logic [3:0] SEL_PEND2      = 4'd2;
   localparam logic [3:0] SEL_MASK_FIRST = 4'd3;
   localparam logic [3:0] SEL_MASK_LAST  = 4'd11;

   localparam logic [1:0] WORD_NONE = 2'd3;

   localparam logic [31:0] W0_CLEARABLE = 32'h3FFF_FFFF;
   localparam logic [31:0] KEEP_BUT_31  = 32'h7FFF_FFFF;
   localparam logic [31:0] KEEP_BUT_30  = 32'hBFFF_FFFF;

   typedef struct packed {
      cmd_type     cmd;
      logic [6:0]  event_number;
      logic [3:0]  reg_select;
      logic [31:0] write_data;
   } req_item_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_a;
      logic        irq_b;
      logic        irq_c;
   } rsp_item_type;

endpackage

@@ design/cascaded_event_interrupt_controller.sv @@
// Cascaded event interrupt controller: 96 event flags in three pending words,
// with events in words 1 and 2 summarized by cascade bits 30 and 31 of word 0,
// and three interrupt lines, each the OR of pending AND its own mask set. One
// beat per cycle in each direction unless the response side stalls; every
// accepted request beat (raise, clear, register write or register read) yields
// exactly one response beat carrying the read data and the three line levels
// after that beat's update. A beat passes an input register, then the response
// register; the read-modify-write of the flop-based pending and mask words
// completes between them, so back-to-back beats see each other's effects.
module cascaded_event_interrupt_controller import ceic_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [6:0] event_number, [10:7] reg_select, [42:11] write_data, [47:43] zero
   input  logic [47:0] req_tdata,
   // [1:0] cmd
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] read_data, [32] irq_a, [33] irq_b, [34] irq_c, [39:35] zero
   output logic [39:0] rsp_tdata
);

   logic         out_free;
   logic         fire;
   req_item_type item;
   rsp_item_type result;

   ceic_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .out_free   (out_free),
      .fire       (fire),
      .item       (item)
   );

   ceic_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .result (result)
   );

   ceic_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .result     (result),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ design/ceic_in_stage.sv @@
module ceic_in_stage import ceic_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         out_free,
   output logic         fire,
   output req_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   req_item_type item_in;
   logic         take;

   assign req_tready = !valid_ff || out_free;
   assign take       = req_tvalid && req_tready;
   assign fire       = valid_ff && out_free;
   assign item       = item_ff;

   always_comb begin
      valid_in = take || (valid_ff && !fire);
      item_in  = item_ff;
      if (take) begin
         item_in.cmd          = cmd_type'(req_tuser);
         item_in.event_number = req_tdata[6:0];
         item_in.reg_select   = req_tdata[10:7];
         item_in.write_data   = req_tdata[42:11];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

@@ design/ceic_core.sv @@
`include "cascaded_event_interrupt_controller_macros.svh"

module ceic_core import ceic_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   output rsp_item_type result
);

   logic [PEND_WORDS-1:0][31:0] pend_ff;
   logic [PEND_WORDS-1:0][31:0] pend_in;
   logic [MASK_WORDS-1:0][31:0] mask_ff;
   logic [MASK_WORDS-1:0][31:0] mask_in;
   logic [1:0]                  word;
   logic [4:0]                  bit_idx;
   logic [3:0]                  mask_idx;
   logic [31:0]                 read_data;
   logic [2:0]                  irq;

   assign word     = item.event_number[6:5];
   assign bit_idx  = item.event_number[4:0];
   assign mask_idx = item.reg_select - SEL_MASK_FIRST;

   always_comb begin
      pend_in   = pend_ff;
      mask_in   = mask_ff;
      read_data = '0;
      unique case (item.cmd)
         CMD_RAISE: begin
            if (word != WORD_NONE) begin
               pend_in[word][bit_idx] = 1'b1;
               if (word == 2'd2) begin
                  pend_in[0] = pend_in[0] | ~KEEP_BUT_31;
               end else if (word == 2'd1) begin
                  pend_in[0] = pend_in[0] | ~KEEP_BUT_30;
               end
            end
         end
         CMD_CLEAR: begin
            if (word != WORD_NONE) begin
               pend_in[word][bit_idx] = 1'b0;
               if (pend_in[word] == '0) begin
                  if (word == 2'd2) begin
                     pend_in[0] = pend_in[0] & KEEP_BUT_31;
                  end else if (word == 2'd1) begin
                     pend_in[0] = pend_in[0] & KEEP_BUT_30;
                  end
               end
            end
         end
         CMD_WRITE: begin
            unique case (item.reg_select) inside
               SEL_PEND0: begin
                  pend_in[0] = pend_ff[0] & ~(item.write_data & W0_CLEARABLE);
               end
               SEL_PEND2: begin
                  pend_in[2] = pend_ff[2] & ~item.write_data;
                  if (pend_in[2] == '0) begin
                     pend_in[0] = pend_in[0] & KEEP_BUT_31;
                  end
               end
               [SEL_MASK_FIRST:SEL_MASK_LAST]: begin
                  mask_in[mask_idx] = item.write_data;
               end
               default: begin
               end
            endcase
         end
         CMD_READ: begin
            unique case (item.reg_select) inside
               SEL_PEND0:                     read_data = pend_ff[0];
               SEL_PEND1:                     read_data = pend_ff[1];
               SEL_PEND2:                     read_data = pend_ff[2];
               [SEL_MASK_FIRST:SEL_MASK_LAST]: read_data = mask_ff[mask_idx];
               default:                       read_data = '0;
            endcase
         end
         default: begin
         end
      endcase
   end

   // Lines follow the state after this beat's update.
   always_comb begin
      for (int s = 0; s < 3; s++) begin
         irq[s] = |((pend_in[0] & mask_in[s*3])
                  | (pend_in[1] & mask_in[s*3+1])
                  | (pend_in[2] & mask_in[s*3+2]));
      end
   end

   assign result.read_data = read_data;
   assign result.irq_a     = irq[0];
   assign result.irq_b     = irq[1];
   assign result.irq_c     = irq[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         mask_ff <= '0;
      end else if (fire) begin
         pend_ff <= pend_in;
         mask_ff <= mask_in;
      end
   end

   `CEIC_ASSERT_NEXT(a_idle_hold, clock, reset, !fire, $stable(pend_ff) && $stable(mask_ff))
   `CEIC_ASSERT_NEXT(a_read_no_side_effect, clock, reset, fire && item.cmd == CMD_READ, $stable(pend_ff) && $stable(mask_ff))
   `CEIC_ASSERT_NEXT(a_word1_read_only, clock, reset, fire && item.cmd == CMD_WRITE, $stable(pend_ff[1]))
   `CEIC_ASSERT_NEXT(a_cascade_on_raise, clock, reset, fire && item.cmd == CMD_RAISE && word == 2'd2, pend_ff[0][31] && pend_ff[2] != '0)

endmodule

@@ design/ceic_out_reg.sv @@
module ceic_out_reg import ceic_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type result,
   output logic         out_free,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type data_ff;
   rsp_item_type data_in;

   assign out_free   = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'b0, data_ff.irq_c, data_ff.irq_b, data_ff.irq_a, data_ff.read_data};

   always_comb begin
      valid_in = load || (valid_ff && !rsp_tready);
      data_in  = load ? result : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule

@@ tb/testbench.sv @@
module testbench import ceic_pkg::*;;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_BURSTY
   } ready_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [6:0] event_number, [10:7] reg_select, [42:11] write_data, [47:43] zero
   logic [47:0] req_tdata = '0;
   // [1:0] cmd
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [31:0] read_data, [32] irq_a, [33] irq_b, [34] irq_c, [39:35] zero
   logic [39:0] rsp_tdata;

   logic [31:0]    pend_word [PEND_WORDS];
   logic [31:0]    mask_word [MASK_WORDS];
   rsp_item_type   predicted_rsp [$];
   rsp_item_type   want_rsp;
   rsp_item_type   got_rsp;
   int             mismatches = 0;
   ready_mode_type ready_mode = READY_ALWAYS;
   int             ready_hold = 0;
   bit             gaps_on = 1'b0;
   int             burst_left = 0;

   cascaded_event_interrupt_controller u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Pending/mask update for one request beat; returns the response it yields.
   function automatic rsp_item_type update_event_state(req_item_type it);
      rsp_item_type r;
      logic [1:0]   w;
      logic [4:0]   b;
      r = '0;
      w = it.event_number[6:5];
      b = it.event_number[4:0];
      case (it.cmd)
         CMD_RAISE: begin
            if (w != WORD_NONE) begin
               pend_word[w][b] = 1'b1;
               if (w == 2'd2) pend_word[0] = pend_word[0] | ~KEEP_BUT_31;
               else if (w == 2'd1) pend_word[0] = pend_word[0] | ~KEEP_BUT_30;
            end
         end
         CMD_CLEAR: begin
            if (w != WORD_NONE) begin
               pend_word[w][b] = 1'b0;
               if (pend_word[w] == '0) begin
                  if (w == 2'd2) pend_word[0] = pend_word[0] & KEEP_BUT_31;
                  else if (w == 2'd1) pend_word[0] = pend_word[0] & KEEP_BUT_30;
               end
            end
         end
         CMD_WRITE: begin
            if (it.reg_select == SEL_PEND0) begin
               pend_word[0] = pend_word[0] & ~(it.write_data & W0_CLEARABLE);
            end else if (it.reg_select == SEL_PEND2) begin
               pend_word[2] = pend_word[2] & ~it.write_data;
               if (pend_word[2] == '0) pend_word[0] = pend_word[0] & KEEP_BUT_31;
            end else if (it.reg_select >= SEL_MASK_FIRST && it.reg_select <= SEL_MASK_LAST) begin
               mask_word[it.reg_select - SEL_MASK_FIRST] = it.write_data;
            end
         end
         CMD_READ: begin
            if (it.reg_select <= SEL_PEND2) r.read_data = pend_word[it.reg_select[1:0]];
            else if (it.reg_select <= SEL_MASK_LAST)
               r.read_data = mask_word[it.reg_select - SEL_MASK_FIRST];
         end
         default: ;
      endcase
      for (int i = 0; i < PEND_WORDS; i++) begin
         r.irq_a = r.irq_a | (|(pend_word[i] & mask_word[i]));
         r.irq_b = r.irq_b | (|(pend_word[i] & mask_word[PEND_WORDS + i]));
         r.irq_c = r.irq_c | (|(pend_word[i] & mask_word[2 * PEND_WORDS + i]));
      end
      return r;
   endfunction

   function automatic req_item_type make_req(cmd_type cmd, logic [6:0] ev,
                                             logic [3:0] sel, logic [31:0] data);
      req_item_type it;
      it.cmd          = cmd;
      it.event_number = ev;
      it.reg_select   = sel;
      it.write_data   = data;
      return it;
   endfunction

   function automatic req_item_type random_req();
      req_item_type it;
      int           pick;
      logic [1:0]   w;
      logic [4:0]   b;
      it.event_number = 7'($urandom_range(0, 127));
      it.reg_select   = 4'($urandom_range(0, 15));
      it.write_data   = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 40) it.cmd = CMD_RAISE;
      else if (pick < 65) it.cmd = CMD_CLEAR;
      else if (pick < 83) it.cmd = CMD_WRITE;
      else it.cmd = CMD_READ;
      // few bits per word, so words fill up and drain back to empty
      if ($urandom_range(0, 9) < 7) begin
         w = 2'($urandom_range(0, 2));
         b = 5'($urandom_range(0, 3));
         it.event_number = {w, b};
      end
      if ($urandom_range(0, 3) != 0) it.reg_select = 4'($urandom_range(0, 11));
      case ($urandom_range(0, 5))
         0: it.write_data = 32'h1 << $urandom_range(0, 31);
         1: it.write_data = it.write_data & $urandom();
         2: it.write_data = '0;
         3: it.write_data = '1;
         4: it.write_data = 32'hF << (4 * $urandom_range(0, 7));
         default: ;
      endcase
      return it;
   endfunction

   task automatic send_beat(input req_item_type it);
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, it.write_data, it.reg_select, it.event_number};
      req_tuser  <= it.cmd;
      do @(posedge clock); while (!req_tready);
      predicted_rsp.push_back(update_event_state(it));
      if (gaps_on) begin
         if (burst_left == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(0, 12);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (predicted_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) send_beat(random_req());
   endtask

   task automatic test_directed();
      gaps_on    = 1'b0;
      ready_mode = READY_ALWAYS;
      send_beat(make_req(CMD_WRITE, 7'd0, SEL_MASK_FIRST, 32'hFFFF_FFFF));
      send_beat(make_req(CMD_WRITE, 7'd0, 4'd7, 32'hFFFF_FFFF));
      send_beat(make_req(CMD_WRITE, 7'd0, SEL_MASK_LAST, 32'h8000_0001));
      send_beat(make_req(CMD_RAISE, 7'd0, 4'd0, 32'h0));
      send_beat(make_req(CMD_RAISE, 7'd32, 4'd0, 32'h0));
      send_beat(make_req(CMD_RAISE, 7'd95, 4'd0, 32'h0));
      // word index 3 does not exist
      send_beat(make_req(CMD_RAISE, 7'd96, 4'd0, 32'h0));
      send_beat(make_req(CMD_RAISE, 7'd127, 4'd15, 32'hFFFF_FFFF));
      send_beat(make_req(CMD_READ, 7'd0, SEL_PEND0, 32'h0));
      send_beat(make_req(CMD_READ, 7'd0, SEL_PEND1, 32'h0));
      send_beat(make_req(CMD_READ, 7'd0, SEL_PEND2, 32'h0));
      // cascade bits survive; word 1 is read-only
      send_beat(make_req(CMD_WRITE, 7'd0, SEL_PEND0, 32'hFFFF_FFFF));
      send_beat(make_req(CMD_WRITE, 7'd0, SEL_PEND1, 32'hFFFF_FFFF));
      send_beat(make_req(CMD_READ, 7'd0, SEL_PEND0, 32'h0));
      send_beat(make_req(CMD_CLEAR, 7'd32, 4'd0, 32'h0));
      send_beat(make_req(CMD_WRITE, 7'd0, SEL_PEND2, 32'h8000_0000));
      send_beat(make_req(CMD_RAISE, 7'd30, 4'd0, 32'h0));
      send_beat(make_req(CMD_CLEAR, 7'd31, 4'd0, 32'h0));
      send_beat(make_req(CMD_WRITE, 7'd0, 4'd12, 32'hFFFF_FFFF));
      send_beat(make_req(CMD_WRITE, 7'd0, 4'd15, 32'hFFFF_FFFF));
      send_beat(make_req(CMD_READ, 7'd0, SEL_MASK_LAST, 32'h0));
      send_beat(make_req(CMD_READ, 7'd0, 4'd12, 32'h0));
      send_beat(make_req(CMD_READ, 7'd127, 4'd15, 32'hFFFF_FFFF));
      send_beat(make_req(CMD_CLEAR, 7'd127, 4'd0, 32'h0));
      send_beat(make_req(CMD_WRITE, 7'd0, SEL_MASK_FIRST, 32'h0));
      drain_responses();
   endtask

   task automatic test_streaming();
      gaps_on    = 1'b0;
      ready_mode = READY_ALWAYS;
      send_random(300);
      drain_responses();
   endtask

   task automatic test_bursts();
      gaps_on    = 1'b1;
      burst_left = 0;
      ready_mode = READY_RANDOM;
      send_random(300);
      drain_responses();
   endtask

   task automatic test_backpressure();
      gaps_on    = 1'b1;
      burst_left = 0;
      ready_mode = READY_BURSTY;
      send_random(300);
      drain_responses();
   endtask

   always @(posedge clock) begin
      case (ready_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_RANDOM: rsp_tready <= ($urandom_range(0, 2) != 0);
         default: begin
            if (ready_hold == 0) begin
               rsp_tready <= !rsp_tready;
               ready_hold <= $urandom_range(1, 16);
            end else begin
               ready_hold <= ready_hold - 1;
            end
         end
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_rsp.read_data = rsp_tdata[31:0];
         got_rsp.irq_a     = rsp_tdata[32];
         got_rsp.irq_b     = rsp_tdata[33];
         got_rsp.irq_c     = rsp_tdata[34];
         if (predicted_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response beat: rd=%h a=%b b=%b c=%b",
                        got_rsp.read_data, got_rsp.irq_a, got_rsp.irq_b, got_rsp.irq_c);
         end else begin
            want_rsp = predicted_rsp.pop_front();
            if (got_rsp.read_data !== want_rsp.read_data || got_rsp.irq_a !== want_rsp.irq_a ||
                got_rsp.irq_b !== want_rsp.irq_b || got_rsp.irq_c !== want_rsp.irq_c) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected rd=%h a=%b b=%b c=%b, got rd=%h a=%b b=%b c=%b",
                           want_rsp.read_data, want_rsp.irq_a, want_rsp.irq_b, want_rsp.irq_c,
                           got_rsp.read_data, got_rsp.irq_a, got_rsp.irq_b, got_rsp.irq_c);
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < PEND_WORDS; i++) pend_word[i] = '0;
      for (int i = 0; i < MASK_WORDS; i++) mask_word[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_streaming();
      test_bursts();
      test_backpressure();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && predicted_rsp.size() == 0) begin
         $display("cascaded_event_interrupt_controller test passed");
      end else begin
         $display("cascaded_event_interrupt_controller test failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("cascaded_event_interrupt_controller test failed");
      $finish;
   end

endmodule
